### design/bcpq_pkg.sv
// shared types and constants of the byte capacity packet queue
// no dependencies; imported by bcpq_desc_fifo, the core, the result checker and tb_top
package bcpq_pkg;

  localparam int DEPTH = 64;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 1'd1;

  typedef enum logic [1:0] {
    REQ_ARRIVAL = 2'd0,
    REQ_SERVE   = 2'd1,
    REQ_TICK    = 2'd2
  } req_type_t;

  typedef enum logic {
    PH_WAITING = 1'b0,
    PH_READY   = 1'b1
  } phase_t;

  typedef enum logic {
    KIND_REPORT = 1'b0,
    KIND_PACKET = 1'b1
  } out_kind_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] len;
  } desc_t;

  typedef struct packed {
    logic  push;
    logic  pop;
    desc_t push_desc;
  } fifo_ctrl_t;

  typedef struct packed {
    out_kind_t   kind;
    logic [31:0] queued_bytes;
    logic [15:0] dropped_len;
    logic [15:0] out_id;
    logic [15:0] out_len;
    logic        last;
  } result_t;

endpackage

### design/bcpq_desc_fifo.sv
// descriptor fifo with a registered head that shows the oldest entry whenever one is held
// depends on bcpq_pkg
module bcpq_desc_fifo (
  input  logic                        clk,
  input  logic                        rst,
  input  bcpq_pkg::fifo_ctrl_t        ctrl,
  output logic [bcpq_pkg::CNT_W-1:0]  count,
  output bcpq_pkg::desc_t             head
);
  import bcpq_pkg::*;

  desc_t            mem [DEPTH];
  logic [PTR_W-1:0] head_ptr;
  logic [PTR_W-1:0] tail_ptr;
  logic [PTR_W-1:0] head_ptr_next;
  logic [PTR_W-1:0] tail_ptr_next;
  logic [CNT_W-1:0] count_next;

  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  always_comb begin
    head_ptr_next = head_ptr;
    tail_ptr_next = tail_ptr;
    count_next    = count;
    if (ctrl.pop) begin
      head_ptr_next = (head_ptr == LAST_PTR) ? '0 : head_ptr + 1'b1;
    end
    if (ctrl.push) begin
      tail_ptr_next = (tail_ptr == LAST_PTR) ? '0 : tail_ptr + 1'b1;
    end
    case ({ctrl.push, ctrl.pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr <= '0;
      tail_ptr <= '0;
      count    <= '0;
    end else begin
      head_ptr <= head_ptr_next;
      tail_ptr <= tail_ptr_next;
      count    <= count_next;
    end
  end

  // storage write and prefetch of the next head, with write-through
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[tail_ptr] <= ctrl.push_desc;
    end
    if (ctrl.push && (tail_ptr == head_ptr_next)) begin
      head <= ctrl.push_desc;
    end else begin
      head <= mem[head_ptr_next];
    end
  end

endmodule

### design/byte_capacity_packet_queue_core.sv
// byte capacity packet queue: tail-drop descriptor fifo with server pull handshake
// output: the first result of an item is registered and presented in the cycle after it is accepted
// input flow: an item causing k results (0 to 3) holds off the next item until only its last
//   result is left and is being taken, set by the single result channel draining a three-entry result buffer
// reset: synchronous, active high; clears queue, counters and phase, capacity to all ones
//   and period to 0
// depends on bcpq_pkg and bcpq_desc_fifo
module byte_capacity_packet_queue_core (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_wen,
  input  logic [bcpq_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [31:0]                       cfg_wdata,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [31:0]                       s_tdata,   // pkt_id[15:0], pkt_len[31:16]
  input  logic [1:0]                        s_tuser,   // req_type[1:0]
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [79:0]                       m_tdata,   // queued_bytes[31:0], dropped_len[47:32],
                                                       // out_id[63:48], out_len[79:64]
  output logic [0:0]                        m_tuser,   // out_kind[0]
  output logic                              m_tlast
);
  import bcpq_pkg::*;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  // configuration registers
  logic [31:0] capacity_bytes;
  logic [31:0] period_ticks;

  // control state
  phase_t      phase, phase_next;
  logic        server_waiting, server_waiting_next;
  logic [31:0] countdown, countdown_next;
  logic [31:0] byte_total, byte_total_next;

  // fifo interface
  fifo_ctrl_t       fctrl;
  logic [CNT_W-1:0] entry_count;
  desc_t            head_desc;

  // result buffer, slot 0 is the one on the output
  result_t     slot [3];
  logic [1:0]  out_cnt;
  result_t     res [3];
  logic [1:0]  res_cnt;

  logic        accept;
  req_type_t   req;
  desc_t       in_desc;

  // notify chain operands
  logic        do_notify;
  logic [31:0] nfy_bytes;
  logic [15:0] nfy_drop;
  logic        nfy_emit;
  desc_t       nfy_head;

  logic [32:0] want;
  logic        drop;

  function automatic result_t mk_report(logic [31:0] bytes, logic [15:0] dl, logic lst);
    result_t r;
    r              = '0;
    r.kind         = KIND_REPORT;
    r.queued_bytes = bytes;
    r.dropped_len  = dl;
    r.last         = lst;
    return r;
  endfunction

  function automatic result_t mk_emit(desc_t d, logic lst);
    result_t r;
    r         = '0;
    r.kind    = KIND_PACKET;
    r.out_id  = d.id;
    r.out_len = d.len;
    r.last    = lst;
    return r;
  endfunction

  assign accept  = s_tvalid && s_tready;
  assign req     = req_type_t'(s_tuser);
  assign in_desc = '{id: s_tdata[15:0], len: s_tdata[31:16]};

  // room for a new item once at most the last buffered result leaves now
  assign s_tready = (out_cnt == 2'd0) || ((out_cnt == 2'd1) && m_tready);

  // arrival admission check: byte capacity and entry depth
  assign want = {1'b0, byte_total} + {17'b0, in_desc.len};
  assign drop = (want > {1'b0, capacity_bytes}) || (entry_count == FULL_CNT);

  always_comb begin
    phase_next          = phase;
    server_waiting_next = server_waiting;
    countdown_next      = countdown;
    byte_total_next     = byte_total;
    fctrl               = '0;
    fctrl.push_desc     = in_desc;
    do_notify           = 1'b0;
    nfy_bytes           = byte_total;
    nfy_drop            = '0;
    nfy_emit            = 1'b0;
    nfy_head            = head_desc;
    res[0]              = '0;
    res[1]              = '0;
    res[2]              = '0;
    res_cnt             = 2'd0;

    case (req)
      REQ_ARRIVAL: begin
        do_notify = 1'b1;
        if (drop) begin
          nfy_drop = in_desc.len;
          nfy_emit = server_waiting && (entry_count != '0);
        end else begin
          fctrl.push = 1'b1;
          nfy_bytes  = want[31:0];
          nfy_emit   = server_waiting;
          // an empty queue has the arriving packet as its head
          if (entry_count == '0) begin
            nfy_head = in_desc;
          end
        end
      end
      REQ_SERVE: begin
        server_waiting_next = 1'b1;
        phase_next          = PH_READY;
        if (entry_count != '0) begin
          fctrl.pop           = 1'b1;
          server_waiting_next = 1'b0;
          phase_next          = PH_WAITING;
          countdown_next      = period_ticks;
          byte_total_next     = byte_total - {16'b0, head_desc.len};
          res[0]              = mk_emit(head_desc, 1'b0);
          res[1]              = mk_report(byte_total_next, 16'd0, 1'b1);
          res_cnt             = 2'd2;
        end
      end
      REQ_TICK: begin
        if (period_ticks != '0) begin
          if (countdown >= 32'd2) begin
            countdown_next = countdown - 32'd1;
          end else if (phase == PH_READY) begin
            phase_next     = PH_WAITING;
            countdown_next = period_ticks;
          end else begin
            // expiry while waiting: server is taken as waiting
            server_waiting_next = 1'b1;
            do_notify           = 1'b1;
            nfy_emit            = (entry_count != '0);
          end
        end
      end
      default: begin
      end
    endcase

    // notify chain: report, optional head emission and second report
    if (do_notify) begin
      phase_next      = PH_WAITING;
      countdown_next  = period_ticks;
      byte_total_next = nfy_bytes;
      res[0]          = mk_report(nfy_bytes, nfy_drop, !nfy_emit);
      res_cnt         = 2'd1;
      if (nfy_emit) begin
        fctrl.pop           = 1'b1;
        server_waiting_next = 1'b0;
        byte_total_next     = nfy_bytes - {16'b0, nfy_head.len};
        res[1]              = mk_emit(nfy_head, 1'b0);
        res[2]              = mk_report(byte_total_next, 16'd0, 1'b1);
        res_cnt             = 2'd3;
      end
    end

    if (!accept) begin
      fctrl.push = 1'b0;
      fctrl.pop  = 1'b0;
    end
  end

  bcpq_desc_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (fctrl),
    .count (entry_count),
    .head  (head_desc)
  );

  // configuration and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_bytes <= 32'hFFFF_FFFF;
      period_ticks   <= '0;
      phase          <= PH_WAITING;
      server_waiting <= 1'b0;
      countdown      <= '0;
      byte_total     <= '0;
    end else begin
      if (cfg_wen) begin
        case (cfg_addr)
          CFG_CAPACITY: capacity_bytes <= cfg_wdata;
          CFG_PERIOD:   period_ticks   <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (accept) begin
        phase          <= phase_next;
        server_waiting <= server_waiting_next;
        countdown      <= countdown_next;
        byte_total     <= byte_total_next;
      end
    end
  end

  // result buffer fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      out_cnt <= 2'd0;
    end else if (accept) begin
      out_cnt <= res_cnt;
    end else if (m_tvalid && m_tready) begin
      out_cnt <= out_cnt - 2'd1;
    end
  end

  // result buffer payload, loaded on accept, else shifts toward slot 0 on each output transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      slot[0] <= res[0];
      slot[1] <= res[1];
      slot[2] <= res[2];
    end else if (m_tvalid && m_tready) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

  assign m_tvalid = (out_cnt != 2'd0);
  assign m_tdata  = {slot[0].out_len, slot[0].out_id, slot[0].dropped_len,
                     slot[0].queued_bytes};
  assign m_tuser  = slot[0].kind;
  assign m_tlast  = slot[0].last;

endmodule

### tb/sv/bcpq_result_checker.sv
// result checker for byte_capacity_packet_queue_core: mirrors the descriptor queue,
// predicts every result of each accepted request and compares it on the result stream
// depends on bcpq_pkg
`timescale 1ns / 100ps

module bcpq_result_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wen,
  input  logic [bcpq_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [31:0]                    cfg_wdata,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [31:0]                    s_tdata,   // pkt_id[15:0], pkt_len[31:16]
  input  logic [1:0]                     s_tuser,   // req_type[1:0]
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [79:0]                    m_tdata,   // queued_bytes[31:0], dropped_len[47:32],
                                                    // out_id[63:48], out_len[79:64]
  input  logic [0:0]                     m_tuser,   // out_kind[0]
  input  logic                           m_tlast,
  output int                             fail_count,
  output int                             pending_results
);
  import bcpq_pkg::*;

  // mirrored registers and queue state
  logic [31:0] cap_limit;
  logic [31:0] period_len;
  phase_t      phase;
  logic        srv_waiting;
  logic [31:0] countdown;
  desc_t       slots [DEPTH];
  int          head_ix;
  int          tail_ix;
  int          held;
  logic [31:0] byte_total;
  logic [15:0] drop_len;

  result_t     batch[$];
  result_t     awaited_results[$];
  int          mismatches = 0;

  function automatic void push_report();
    result_t r;
    r = '0;
    r.kind = KIND_REPORT;
    r.queued_bytes = byte_total;
    r.dropped_len = drop_len;
    batch.insert(batch.size(), r);
    drop_len = '0;
  endfunction

  function automatic void push_head();
    result_t r;
    desc_t d;
    d = slots[head_ix];
    r = '0;
    r.kind = KIND_PACKET;
    r.out_id = d.id;
    r.out_len = d.len;
    batch.insert(batch.size(), r);
    head_ix = (head_ix + 1) % DEPTH;
    held--;
    byte_total = byte_total - 32'(d.len);
    srv_waiting = 1'b0;
  endfunction

  function automatic void back_to_waiting();
    phase = PH_WAITING;
    countdown = period_len;
  endfunction

  function automatic void notify_server();
    push_report();
    if (srv_waiting && held > 0) begin
      push_head();
      push_report();
    end
    back_to_waiting();
  endfunction

  // works out the results of one request and queues them for comparison
  function automatic void predict_request(logic [1:0] kind, logic [15:0] id, logic [15:0] len);
    logic [32:0] want;
    batch.delete();
    case (kind)
      REQ_ARRIVAL: begin
        want = {1'b0, byte_total} + 33'(len);
        if (want > {1'b0, cap_limit} || held >= DEPTH) begin
          drop_len = len;
        end else begin
          slots[tail_ix].id = id;
          slots[tail_ix].len = len;
          tail_ix = (tail_ix + 1) % DEPTH;
          held++;
          byte_total = want[31:0];
        end
        notify_server();
      end
      REQ_SERVE: begin
        srv_waiting = 1'b1;
        phase = PH_READY;
        if (held > 0) begin
          push_head();
          push_report();
          back_to_waiting();
        end
      end
      REQ_TICK: begin
        if (period_len != 0) begin
          if (countdown >= 2) begin
            countdown = countdown - 1;
          end else if (phase == PH_READY) begin
            back_to_waiting();
          end else begin
            srv_waiting = 1'b1;
            notify_server();
          end
        end
      end
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) awaited_results.insert(awaited_results.size(), batch[i]);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    result_t exp_res;
    if (rst) begin
      cap_limit = '1;
      period_len = '0;
      phase = PH_WAITING;
      srv_waiting = 1'b0;
      countdown = '0;
      head_ix = 0;
      tail_ix = 0;
      held = 0;
      byte_total = '0;
      drop_len = '0;
      awaited_results.delete();
    end else begin
      if (cfg_wen) begin
        if (cfg_addr == CFG_CAPACITY) cap_limit = cfg_wdata;
        else if (cfg_addr == CFG_PERIOD) period_len = cfg_wdata;
      end
      if (m_tvalid && m_tready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0d data %h last %b",
                   $time, m_tuser[0], m_tdata, m_tlast);
          mismatches++;
        end else begin
          exp_res = awaited_results[0];
          awaited_results.delete(0);
          check_field("out_kind", 32'(exp_res.kind), 32'(m_tuser[0]));
          check_field("queued_bytes", exp_res.queued_bytes, m_tdata[31:0]);
          check_field("dropped_len", 32'(exp_res.dropped_len), 32'(m_tdata[47:32]));
          check_field("out_id", 32'(exp_res.out_id), 32'(m_tdata[63:48]));
          check_field("out_len", 32'(exp_res.out_len), 32'(m_tdata[79:64]));
          check_field("last", 32'(exp_res.last), 32'(m_tlast));
        end
      end
      if (s_tvalid && s_tready) predict_request(s_tuser, s_tdata[15:0], s_tdata[31:16]);
    end
    fail_count <= mismatches;
    pending_results <= awaited_results.size();
  end

endmodule

### tb/sv/tb_top.sv
// top of the packet queue testbench: clock, reset, request stimulus and result sink
// depends on bcpq_pkg, byte_capacity_packet_queue_core and bcpq_result_checker
`timescale 1ns / 100ps

module tb_top;
  import bcpq_pkg::*;

  // request code the block ignores
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  // cycles allowed after the last result before the block counts as idle
  localparam int SETTLE_CYCLES = 8;
  // receiver hold-off long enough to back the block up into its input
  localparam int LONG_HOLD = 200;
  localparam int RANDOM_PHASES = 5;
  localparam int ITEMS_PER_PHASE = 40;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = CFG_CAPACITY;
  logic [31:0]          cfg_wdata = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [31:0]          s_tdata = '0;   // pkt_id[15:0], pkt_len[31:16]
  logic [1:0]           s_tuser = REQ_ARRIVAL;   // req_type[1:0]
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [79:0]          m_tdata;   // queued_bytes[31:0], dropped_len[47:32],
                                   // out_id[63:48], out_len[79:64]
  logic [0:0]           m_tuser;   // out_kind[0]
  logic                 m_tlast;

  int fail_count;
  int results_due;
  // bumped by the stimulus to ask the receiver for one long hold-off
  int hold_asks = 0;

  always #5 clk = ~clk;

  byte_capacity_packet_queue_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  bcpq_result_checker i_results (
    .clk             (clk),
    .rst             (rst),
    .cfg_wen         (cfg_wen),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .m_tlast         (m_tlast),
    .fail_count      (fail_count),
    .pending_results (results_due)
  );

  // present one request and hold it until the transaction completes;
  // tvalid stays high on return so back-to-back requests need no extra step
  task automatic send_item(logic [1:0] kind, logic [15:0] id, logic [15:0] len);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {len, id};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic pause_sender(int cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // sender goes quiet until every predicted result has come back, then lets
  // the block settle in case the last request made no result at all
  task automatic drain_all();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register writes only ever happen with the block idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    drain_all();
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // result sink: stretches of always-ready, mostly-ready, mostly-stalled and
  // toggling, plus one long hold-off whenever the stimulus asks for it
  initial begin : result_sink
    int mode;
    int span;
    int hold_seen;
    hold_seen = 0;
    forever begin
      span = $urandom_range(10, 120);
      mode = $urandom_range(0, 3);
      repeat (span) begin
        @(posedge clk);
        if (hold_asks != hold_seen) begin
          hold_seen = hold_asks;
          m_tready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
        end
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ~m_tready;
        endcase
      end
    end
  end

  initial begin : stimulus
    int burst;
    int roll;
    logic [1:0]  kind;
    logic [15:0] len;
    logic [31:0] cap;
    logic [31:0] per;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, capacity unlimited and no forced period
    send_item(REQ_SERVE, 16'h0000, 16'h0000);     // request on an empty queue
    send_item(REQ_TICK, 16'h0000, 16'h0000);      // tick ignored with period off
    send_item(REQ_UNUSED, 16'hFFFF, 16'hFFFF);    // unused request code
    send_item(REQ_ARRIVAL, 16'hFFFF, 16'hFFFF);   // waiting server gets it right away
    send_item(REQ_ARRIVAL, 16'h0000, 16'h0000);   // zero-length packet still queued
    send_item(REQ_ARRIVAL, 16'hA5A5, 16'h5A5A);
    send_item(REQ_SERVE, 16'h0000, 16'h0000);     // serves the zero-length packet
    send_item(REQ_SERVE, 16'h0000, 16'h0000);

    // zero capacity: only zero-length packets fit
    write_reg(CFG_CAPACITY, 32'd0);
    send_item(REQ_ARRIVAL, 16'h0101, 16'h0001);
    send_item(REQ_ARRIVAL, 16'h0202, 16'h0000);
    send_item(REQ_SERVE, 16'h0000, 16'h0000);

    // small capacity: drop on overflow, exact fill accepted
    write_reg(CFG_CAPACITY, 32'd100);
    send_item(REQ_ARRIVAL, 16'h0011, 16'd60);
    send_item(REQ_ARRIVAL, 16'h0022, 16'd60);
    send_item(REQ_ARRIVAL, 16'h0033, 16'd40);
    send_item(REQ_ARRIVAL, 16'h0044, 16'd0);

    // period of one tick: expiry while waiting and while ready
    write_reg(CFG_PERIOD, 32'd1);
    send_item(REQ_TICK, 16'h0000, 16'h0000);
    send_item(REQ_SERVE, 16'h0000, 16'h0000);
    send_item(REQ_SERVE, 16'h0000, 16'h0000);
    send_item(REQ_SERVE, 16'h0000, 16'h0000);
    send_item(REQ_TICK, 16'h0000, 16'h0000);
    send_item(REQ_TICK, 16'h0000, 16'h0000);

    // longer period counts down before expiring
    write_reg(CFG_PERIOD, 32'd3);
    send_item(REQ_ARRIVAL, 16'h5555, 16'hAAAA);
    repeat (3) send_item(REQ_TICK, 16'h0000, 16'h0000);

    write_reg(CFG_PERIOD, 32'hFFFF_FFFF);
    write_reg(CFG_CAPACITY, 32'hFFFF_FFFF);
    send_item(REQ_TICK, 16'h0000, 16'h0000);

    // pressure: receiver holds off while arrivals keep coming, so the result
    // buffer backs up into the input and the entry store runs full
    write_reg(CFG_PERIOD, 32'd0);
    drain_all();
    hold_asks <= hold_asks + 1;
    for (int n = 0; n < DEPTH + 6; n++) begin
      send_item(REQ_ARRIVAL, 16'($urandom), 16'($urandom_range(0, 1500)));
    end
    for (int n = 0; n < DEPTH + 6; n++) begin
      send_item(REQ_SERVE, 16'($urandom), 16'($urandom));
      if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 5));
    end

    // random phases, each with its own register settings
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin
          cap = $urandom_range(0, 200000);
          per = $urandom_range(2, 5);
        end
        1: begin
          cap = '1;
          per = '0;
        end
        2: begin
          cap = $urandom;
          per = 32'd1;
        end
        3: begin
          cap = $urandom_range(0, 3000);
          per = $urandom_range(1, 3);
        end
        default: begin
          cap = $urandom_range(50000, 400000);
          per = $urandom;
        end
      endcase
      write_reg(CFG_CAPACITY, cap);
      write_reg(CFG_PERIOD, per);
      burst = $urandom_range(1, 24);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 45) kind = REQ_ARRIVAL;
        else if (roll < 75) kind = REQ_SERVE;
        else if (roll < 95) kind = REQ_TICK;
        else kind = REQ_UNUSED;
        // mostly modest lengths so the queue holds several packets
        if ($urandom_range(0, 3) == 0) len = 16'($urandom);
        else len = 16'($urandom_range(0, 2000));
        send_item(kind, 16'($urandom), len);
        burst--;
        if (burst == 0) begin
          pause_sender($urandom_range(1, 9));
          burst = $urandom_range(1, 24);
        end else if ($urandom_range(0, 39) == 0) begin
          drain_all();
        end
      end
    end

    drain_all();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### byte_capacity_packet_queue_core.f
design/bcpq_pkg.sv
design/bcpq_desc_fifo.sv
design/byte_capacity_packet_queue_core.sv
tb/sv/bcpq_result_checker.sv
tb/sv/tb_top.sv
